// ----- rtl/core/hrm_pkg.sv -----
// ----------------------------------------------------------------------------
// hrm_pkg
// Shared types and constants for the heart rate measurement parser.
// ----------------------------------------------------------------------------
`default_nettype none

package hrm_pkg;

  localparam int unsigned HRM_RR_SLOTS = 9;

  localparam logic [15:0] ENERGY_HIGH_RESET = 16'd300;
  localparam logic [15:0] ENERGY_LOW_RESET  = 16'd30;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_HIGH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENERGY_LOW  = 1'd1;

  // flags byte bits
  localparam int unsigned FLG_HR16    = 0;
  localparam int unsigned FLG_CONTACT = 1;
  localparam int unsigned FLG_CSUPP   = 2;
  localparam int unsigned FLG_ENERGY  = 3;
  localparam int unsigned FLG_RR      = 4;

  typedef struct packed {
    logic [7:0] pdu_byte;
    logic       end_of_packet;
  } in_word_t;

  typedef struct packed {
    logic [15:0] heart_rate;
    logic        contact_ok;
    logic [15:0] energy_expended;
    logic [3:0]  rr_slot;
    logic [15:0] rr_value;
    logic        request_energy_reset;
    logic        short_packet;
    logic        last_result;
  } out_word_t;

  // per-packet summary handed from the parser to the result side
  typedef struct packed {
    logic [15:0] heart_rate;
    logic        contact_ok;
    logic [15:0] energy;
    logic        request;
    logic        short_pkt;
    logic        rr_on;
  } pkt_info_t;

endpackage

`default_nettype wire

// ----- rtl/core/hrm_front.sv -----
// ----------------------------------------------------------------------------
// hrm_front
// Byte parser: tracks flags, heart rate, energy and RR intervals, runs the
// energy reset latch and hands a packet summary on at end of packet.
// ----------------------------------------------------------------------------
`default_nettype none

module hrm_front
  import hrm_pkg::*;
#(
  parameter int unsigned RR_SLOTS = HRM_RR_SLOTS,
  localparam int unsigned SLOT_W  = (RR_SLOTS > 1) ? $clog2(RR_SLOTS) : 1,
  localparam int unsigned CNT_W   = $clog2(RR_SLOTS + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  byte_vld,
  input  wire in_word_t              byte_in,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output logic                       pkt_push,
  output pkt_info_t                  pkt_info,
  output logic [CNT_W-1:0]           pkt_fill,
  output logic [15:0]                pkt_rr [RR_SLOTS]
);

  logic [15:0]      e_high_r, e_low_r;
  logic [7:0]       flags_r, flags_nxt;
  logic [15:0]      rate_r, rate_nxt;
  logic [15:0]      energy_r, energy_nxt;
  logic [7:0]       pos_r, pos_nxt;
  logic [7:0]       hold_r, hold_nxt;
  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic             latch_r, latch_nxt;
  logic [15:0]      rr_r [RR_SLOTS];
  logic [15:0]      rr_nxt [RR_SLOTS];

  logic [7:0]  b;
  logic [7:0]  hr_end, en_end;
  logic [15:0] word16;
  logic        rr_wr;
  logic        req;
  logic        eop;

  assign b      = byte_in.pdu_byte;
  assign eop    = byte_in.end_of_packet;
  assign word16 = {b, hold_r};

  always_comb begin
    flags_nxt  = flags_r;
    rate_nxt   = rate_r;
    energy_nxt = energy_r;
    hold_nxt   = hold_r;
    fill_nxt   = fill_r;
    rr_wr      = 1'b0;
    rr_nxt     = rr_r;
    hr_end     = flags_r[FLG_HR16] ? 8'd3 : 8'd2;
    en_end     = hr_end + (flags_r[FLG_ENERGY] ? 8'd2 : 8'd0);

    if (pos_r == 8'd0) begin
      flags_nxt = b;
      fill_nxt  = '0;
    end else if (pos_r < hr_end) begin
      if (!flags_r[FLG_HR16]) begin
        rate_nxt = {8'd0, b};
      end else if (pos_r == 8'd1) begin
        hold_nxt = b;
      end else begin
        rate_nxt = word16;
      end
    end else if (pos_r < en_end) begin
      if (pos_r == hr_end) begin
        hold_nxt = b;
      end else begin
        energy_nxt = word16;
      end
    end else if (flags_r[FLG_RR]) begin
      // low byte on even offsets past the energy field; extra intervals dropped
      if (!(pos_r[0] ^ en_end[0])) begin
        hold_nxt = b;
      end else if (fill_r < CNT_W'(RR_SLOTS)) begin
        rr_wr    = 1'b1;
        rr_nxt[fill_r[SLOT_W-1:0]] = word16;
        fill_nxt = fill_r + CNT_W'(1);
      end
    end
  end

  // hysteresis on the stored energy, once per packet
  always_comb begin
    latch_nxt = latch_r;
    req       = 1'b0;
    if (latch_r && (energy_nxt < e_low_r)) begin
      latch_nxt = 1'b0;
    end else if (!latch_r && (energy_nxt > e_high_r)) begin
      latch_nxt = 1'b1;
      req       = 1'b1;
    end
  end

  always_comb begin
    logic [7:0] hr_e, en_e;
    hr_e   = flags_nxt[FLG_HR16] ? 8'd3 : 8'd2;
    en_e   = hr_e + (flags_nxt[FLG_ENERGY] ? 8'd2 : 8'd0);
    if (eop) pos_nxt = 8'd0;
    else if (pos_r == 8'hFF) pos_nxt = pos_r;
    else pos_nxt = pos_r + 8'd1;

    pkt_info.heart_rate = rate_nxt;
    pkt_info.contact_ok = !flags_nxt[FLG_CSUPP] || flags_nxt[FLG_CONTACT];
    pkt_info.energy     = energy_nxt;
    pkt_info.request    = req;
    pkt_info.short_pkt  = ({1'b0, pos_r} + 9'd1) < {1'b0, en_e};
    pkt_info.rr_on      = flags_nxt[FLG_RR];
  end

  assign pkt_push = byte_vld && eop;
  assign pkt_fill = fill_nxt;
  assign pkt_rr   = rr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_high_r <= ENERGY_HIGH_RESET;
      e_low_r  <= ENERGY_LOW_RESET;
      flags_r  <= '0;
      rate_r   <= '0;
      energy_r <= '0;
      pos_r    <= '0;
      hold_r   <= '0;
      fill_r   <= '0;
      latch_r  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          REG_ENERGY_HIGH: e_high_r <= cfg_data;
          REG_ENERGY_LOW:  e_low_r  <= cfg_data;
          default: ;
        endcase
      end
      if (byte_vld) begin
        flags_r  <= flags_nxt;
        rate_r   <= rate_nxt;
        energy_r <= energy_nxt;
        pos_r    <= pos_nxt;
        hold_r   <= hold_nxt;
        fill_r   <= eop ? '0 : fill_nxt;
        if (eop) latch_r <= latch_nxt;
      end
    end
  end

  // slots past the fill count are masked on the way out, so no clear needed
  always_ff @(posedge clk) begin
    if (byte_vld && rr_wr) begin
      rr_r[fill_r[SLOT_W-1:0]] <= word16;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/hrm_back.sv -----
// ----------------------------------------------------------------------------
// hrm_back
// Two-entry packet queue and slot emitter: walks the RR slots of the oldest
// packet into a registered result word.
// ----------------------------------------------------------------------------
`default_nettype none

module hrm_back
  import hrm_pkg::*;
#(
  parameter int unsigned RR_SLOTS = HRM_RR_SLOTS,
  localparam int unsigned SLOT_W  = (RR_SLOTS > 1) ? $clog2(RR_SLOTS) : 1,
  localparam int unsigned CNT_W   = $clog2(RR_SLOTS + 1)
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pkt_push,
  input  wire pkt_info_t        pkt_info,
  input  wire logic [CNT_W-1:0] pkt_fill,
  input  wire logic [15:0]      pkt_rr [RR_SLOTS],
  output logic                  q_full,
  input  wire logic             out_pop,
  output logic                  out_empty,
  output out_word_t             out_data
);

  pkt_info_t        info_q [2];
  logic [CNT_W-1:0] fill_q [2];
  logic [15:0]      rr_q   [2][RR_SLOTS];

  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              out_vld_r, out_vld_nxt;
  out_word_t         out_r;

  logic      q_empty, load, q_pop, last;
  pkt_info_t head;
  out_word_t word_nxt;

  assign q_full    = (cnt_r == 2'd2);
  assign q_empty   = (cnt_r == 2'd0);
  assign load      = !q_empty && (!out_vld_r || out_pop);
  assign last      = (slot_r == SLOT_W'(RR_SLOTS - 1));
  assign q_pop     = load && last;
  assign head      = info_q[rd_ptr_r];

  always_comb begin
    word_nxt.heart_rate           = head.heart_rate;
    word_nxt.contact_ok           = head.contact_ok;
    word_nxt.energy_expended      = head.energy;
    word_nxt.rr_slot              = 4'(slot_r);
    word_nxt.rr_value             = (head.rr_on && (CNT_W'(slot_r) < fill_q[rd_ptr_r]))
                                    ? rr_q[rd_ptr_r][slot_r] : 16'd0;
    word_nxt.request_energy_reset = head.request;
    word_nxt.short_packet         = head.short_pkt;
    word_nxt.last_result          = last;
  end

  always_comb begin
    cnt_nxt = cnt_r + {1'b0, pkt_push} - {1'b0, q_pop};
    slot_nxt = slot_r;
    if (load) slot_nxt = last ? '0 : slot_r + SLOT_W'(1);
    out_vld_nxt = out_vld_r;
    if (load) out_vld_nxt = 1'b1;
    else if (out_pop) out_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= 1'b0;
      rd_ptr_r  <= 1'b0;
      cnt_r     <= '0;
      slot_r    <= '0;
      out_vld_r <= 1'b0;
    end else begin
      if (pkt_push) wr_ptr_r <= !wr_ptr_r;
      if (q_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r     <= cnt_nxt;
      slot_r    <= slot_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pkt_push) begin
      info_q[wr_ptr_r] <= pkt_info;
      fill_q[wr_ptr_r] <= pkt_fill;
      rr_q[wr_ptr_r]   <= pkt_rr;
    end
    if (load) out_r <= word_nxt;
  end

  assign out_empty = !out_vld_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire

// ----- rtl/core/heart_rate_measurement_parser.sv -----
// Output: the end-mark word pushes its packet summary into the queue; the first result
// word is registered; then one word per cycle, RR_SLOTS in all, while out_pop is high.
// Throughput: one input word per cycle while in_full is low; a packet holds the result
// side for RR_SLOTS words; full rises once two packets are held, the one being emitted
// included. Reset: synchronous, active low; clears parser state and the latch and loads
// the energy thresholds with 300 and 30.
// ----------------------------------------------------------------------------
// heart_rate_measurement_parser
// Heart rate measurement notification parser with per-slot result words.
// ----------------------------------------------------------------------------
`default_nettype none

module heart_rate_measurement_parser
  import hrm_pkg::*;
#(
  parameter int unsigned RR_SLOTS = HRM_RR_SLOTS
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  input  wire in_word_t              in_data,
  output logic                       in_full,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output out_word_t                  out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CNT_W = $clog2(RR_SLOTS + 1);

  logic             byte_vld;
  logic             pkt_push;
  pkt_info_t        pkt_info;
  logic [CNT_W-1:0] pkt_fill;
  logic [15:0]      pkt_rr [RR_SLOTS];
  logic             q_full;

  assign byte_vld = in_push && !q_full;
  assign in_full  = q_full;

  hrm_front #(.RR_SLOTS(RR_SLOTS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_vld (byte_vld),
    .byte_in  (in_data),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .pkt_push (pkt_push),
    .pkt_info (pkt_info),
    .pkt_fill (pkt_fill),
    .pkt_rr   (pkt_rr)
  );

  hrm_back #(.RR_SLOTS(RR_SLOTS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pkt_push  (pkt_push),
    .pkt_info  (pkt_info),
    .pkt_fill  (pkt_fill),
    .pkt_rr    (pkt_rr),
    .q_full    (q_full),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
